/* hdl/sths_pkg.sv */
package sths_pkg;

  // default sizes of the key table
  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_KEY_BITS    = 32;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // search sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_FIRST,
    S_GUESS,
    S_HUNT_UP,
    S_HUNT_DN,
    S_BIS_START,
    S_BIS_CMP,
    S_DONE
  } state_t;

endpackage

/* hdl/sths_if.sv */
// request channel: table writes and queries
interface sths_req_if #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned IDX_W    = 10,
  parameter int unsigned LEN_W    = 11
);
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [IDX_W-1:0]           entry_index;
  logic signed [KEY_BITS-1:0] key;
  logic [LEN_W-1:0]           start_guess;

  modport source (output valid, func, entry_index, key, start_guess, input ready);
  modport sink (input valid, func, entry_index, key, start_guess, output ready);
endinterface

// response channel: bracketing index
interface sths_rsp_if #(
  parameter int unsigned LEN_W = 11
);
  logic                    valid;
  logic                    ready;
  logic signed [LEN_W-1:0] lower_index;

  modport source (output valid, lower_index, input ready);
  modport sink (input valid, lower_index, output ready);
endinterface

/* hdl/sorted_table_hunt_search_unit.sv */
// Sorted-table hunt search. A write item (func 0) stores one key in the table and gives no
// response. A query item (func 1) gives one response: the index j with the key between
// entries j and j+1, -1 below the table, n-1 above its end; direction comes from the first
// and last entries. A query reads the last and first entries and the guess, takes the hunt
// steps (none when the guess is not below n), starts bisection, takes the bisection steps
// and loads the output register. Its speed is bounded by the single registered read port of
// the key memory, read once per cycle. One item is searched at a time; a new item is taken
// as soon as the previous result sits in the output register.
module sorted_table_hunt_search_unit #(
  parameter int unsigned TABLE_DEPTH = sths_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BITS    = sths_pkg::DEF_KEY_BITS,
  localparam int unsigned IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned LEN_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  sths_req_if.sink         req,
  sths_rsp_if.source       rsp,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);
  import sths_pkg::*;

  // signed search bounds need room for n plus the doubling hunt step
  localparam int unsigned PW = LEN_W + 2;
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(TABLE_DEPTH);
  localparam logic [LEN_W-1:0] MIN_L   = LEN_W'(2);

  // key memory
  logic signed [KEY_BITS-1:0] mem [TABLE_DEPTH];
  logic signed [KEY_BITS-1:0] rd_data;
  logic [IDX_W-1:0]           rd_addr;
  logic                       mem_we;

  // control and working registers
  state_t                     state, state_next;
  logic [LEN_W-1:0]           table_length;
  logic [LEN_W-1:0]           n_q, n_next;
  logic [LEN_W-1:0]           guess_q, guess_next;
  logic signed [KEY_BITS-1:0] x_q, x_next;
  logic signed [KEY_BITS-1:0] last_q, last_next;
  logic                       asc_q, asc_next;
  logic signed [PW-1:0]       lo, lo_next;
  logic signed [PW-1:0]       hi, hi_next;
  logic signed [PW-1:0]       inc, inc_next;
  logic signed [PW-1:0]       mid_q, mid_next;
  logic                       out_valid;
  logic signed [LEN_W-1:0]    out_idx;

  // combinational helpers
  logic [LEN_W-1:0]     n_eff;
  logic signed [PW-1:0] n_s;
  logic signed [PW-1:0] guess_s;
  logic signed [PW-1:0] inc2;
  logic signed [PW-1:0] lo2;
  logic signed [PW-1:0] hi2;
  logic signed [PW-1:0] mid_c;
  logic                 out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= DEPTH_L;
    end else if (cfg_we) begin
      table_length <= cfg_wdata;
    end
  end

  // length clamped into the legal range
  always_comb begin
    n_eff = table_length;
    if (table_length < MIN_L) begin
      n_eff = MIN_L;
    end else if (table_length > DEPTH_L) begin
      n_eff = DEPTH_L;
    end
  end

  assign n_s      = $signed({2'b00, n_q});
  assign guess_s  = $signed({2'b00, guess_q});
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[req.entry_index] <= req.key;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    n_q     <= n_next;
    guess_q <= guess_next;
    x_q     <= x_next;
    last_q  <= last_next;
    asc_q   <= asc_next;
    lo      <= lo_next;
    hi      <= hi_next;
    inc     <= inc_next;
    mid_q   <= mid_next;
  end

  // next state, memory address and search bounds
  always_comb begin
    state_next = state;
    n_next     = n_q;
    guess_next = guess_q;
    x_next     = x_q;
    last_next  = last_q;
    asc_next   = asc_q;
    lo_next    = lo;
    hi_next    = hi;
    inc_next   = inc;
    mid_next   = mid_q;
    rd_addr    = mid_q[IDX_W-1:0];
    mem_we     = 1'b0;
    inc2       = inc + inc;
    lo2        = lo;
    hi2        = hi;
    mid_c      = mid_q;
    case (state)
      S_IDLE: begin
        rd_addr = IDX_W'(n_eff - LEN_W'(1));
        if (req.valid) begin
          if (req.func == FUNC_WRITE) begin
            mem_we = (LEN_W'(req.entry_index) < DEPTH_L);
          end else begin
            n_next     = n_eff;
            guess_next = req.start_guess;
            x_next     = req.key;
            state_next = S_LAST;
          end
        end
      end
      S_LAST: begin
        // last entry arrives, fetch the first
        last_next  = rd_data;
        rd_addr    = '0;
        state_next = S_FIRST;
      end
      S_FIRST: begin
        asc_next = (last_q > rd_data);
        rd_addr  = guess_q[IDX_W-1:0];
        if (guess_q >= n_q) begin
          lo_next    = '1;
          hi_next    = n_s;
          state_next = S_BIS_START;
        end else begin
          lo_next    = guess_s;
          inc_next   = PW'(1);
          state_next = S_GUESS;
        end
      end
      S_GUESS: begin
        if ((x_q >= rd_data) == asc_q) begin
          // key on the high side of the guess
          hi2     = lo + PW'(1);
          rd_addr = hi2[IDX_W-1:0];
          if (lo == n_s - PW'(1)) begin
            state_next = S_DONE;
          end else begin
            hi_next    = hi2;
            state_next = S_HUNT_UP;
          end
        end else begin
          // key on the low side of the guess
          lo2     = lo - PW'(1);
          rd_addr = lo2[IDX_W-1:0];
          if (lo == '0) begin
            lo_next    = '1;
            state_next = S_DONE;
          end else begin
            hi_next    = lo;
            lo_next    = lo2;
            state_next = S_HUNT_DN;
          end
        end
      end
      S_HUNT_UP: begin
        hi2     = hi + inc2;
        rd_addr = hi2[IDX_W-1:0];
        if ((x_q >= rd_data) == asc_q) begin
          lo_next  = hi;
          inc_next = inc2;
          if (hi2 >= n_s) begin
            hi_next    = n_s;
            state_next = S_BIS_START;
          end else begin
            hi_next = hi2;
          end
        end else begin
          state_next = S_BIS_START;
        end
      end
      S_HUNT_DN: begin
        lo2     = lo - inc2;
        rd_addr = lo2[IDX_W-1:0];
        if ((x_q < rd_data) == asc_q) begin
          hi_next  = lo;
          inc_next = inc2;
          if (inc2 >= lo) begin
            lo_next    = '1;
            state_next = S_BIS_START;
          end else begin
            lo_next = lo2;
          end
        end else begin
          state_next = S_BIS_START;
        end
      end
      S_BIS_START: begin
        mid_c   = (hi + lo) >>> 1;
        rd_addr = mid_c[IDX_W-1:0];
        if (hi - lo == PW'(1)) begin
          state_next = S_DONE;
        end else begin
          mid_next   = mid_c;
          state_next = S_BIS_CMP;
        end
      end
      S_BIS_CMP: begin
        // narrow the bracket and issue the next midpoint
        if ((x_q > rd_data) == asc_q) begin
          lo2 = mid_q;
        end else begin
          hi2 = mid_q;
        end
        mid_c    = (hi2 + lo2) >>> 1;
        rd_addr  = mid_c[IDX_W-1:0];
        lo_next  = lo2;
        hi_next  = hi2;
        mid_next = mid_c;
        if (hi2 - lo2 == PW'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (state == S_DONE && out_free) begin
      out_idx <= lo[LEN_W-1:0];
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.lower_index = out_idx;

`ifndef SYNTHESIS
  // a bisection compare always works on a bracket wider than one
  assert property (@(posedge clk) disable iff (rst)
    state == S_BIS_CMP |-> (hi - lo > PW'(1)) && (mid_q > lo) && (mid_q < hi))
    else $error("bisection bracket collapsed");

  // bounds stay inside -1 .. n when bisection starts
  assert property (@(posedge clk) disable iff (rst)
    state == S_BIS_START |-> (lo >= -PW'(1)) && (hi <= n_s) && (lo < hi))
    else $error("search bounds out of range");

  // a finished search lands in the output register and frees the input
  assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> out_valid && state == S_IDLE)
    else $error("result not loaded");

  // each hunt step that stays in the hunt doubles the step size
  assert property (@(posedge clk) disable iff (rst)
    (state == S_HUNT_UP || state == S_HUNT_DN) && $past(state) == state
      && $past(state_next) == state |-> inc == $past(inc) + $past(inc))
    else $error("hunt step not doubled");
`endif

endmodule
